### sv/ppt_pkg.sv
`timescale 1ns / 1ps

package ppt_pkg;

    localparam int COORD_W = 32;
    localparam int COEF_W  = 32;
    localparam int THR_W   = 31;
    localparam int PADDR_W = 6;
    localparam int PDATA_W = 64;
    localparam int PROD_W  = COEF_W + COORD_W;
    localparam int SUM_W   = PROD_W + 2;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_DEGEN = 2'd1,
        ST_SAT   = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        REG_ROW0_AB = 3'd0,
        REG_A02_A10 = 3'd1,
        REG_ROW1_BC = 3'd2,
        REG_ROW2_AB = 3'd3,
        REG_A22     = 3'd4,
        REG_THRESH  = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] in_u;
        logic signed [COORD_W-1:0] in_v;
        logic                      in_last;
    } in_beat_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] out_u;
        logic signed [COORD_W-1:0] out_v;
        status_t                   point_status;
        logic                      out_last;
    } out_beat_t;

    typedef struct packed {
        logic last;
        logic degen;
        logic sat_u;
        logic sat_v;
        logic neg_u;
        logic neg_v;
    } div_side_t;

endpackage

### sv/ppt_div.sv
`timescale 1ns / 1ps

module ppt_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [ppt_pkg::SUM_W-1:0]     in_dmag,
    input  logic [ppt_pkg::SUM_W-1:0]     in_rem_u,
    input  logic [ppt_pkg::SUM_W-1:0]     in_rem_v,
    input  logic [ppt_pkg::COORD_W-1:0]   in_num_u,
    input  logic [ppt_pkg::COORD_W-1:0]   in_num_v,
    input  ppt_pkg::div_side_t            in_side,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [ppt_pkg::COORD_W-1:0]   quo_u,
    output logic [ppt_pkg::COORD_W-1:0]   quo_v,
    output ppt_pkg::div_side_t            out_side
);
    import ppt_pkg::*;

    localparam int STAGES = COORD_W;

    logic [STAGES-1:0] valid_reg;
    logic [STAGES:0]   adv;

    logic [SUM_W-1:0]   dmag_reg  [STAGES];
    logic [SUM_W-1:0]   rem_u_reg [STAGES];
    logic [SUM_W-1:0]   rem_v_reg [STAGES];
    logic [COORD_W-1:0] num_u_reg [STAGES];
    logic [COORD_W-1:0] num_v_reg [STAGES];
    logic [COORD_W-1:0] quo_u_reg [STAGES];
    logic [COORD_W-1:0] quo_v_reg [STAGES];
    div_side_t          side_reg  [STAGES];

    logic               s_valid [STAGES];
    logic [SUM_W-1:0]   s_dmag  [STAGES];
    logic [SUM_W-1:0]   s_rem_u [STAGES];
    logic [SUM_W-1:0]   s_rem_v [STAGES];
    logic [COORD_W-1:0] s_num_u [STAGES];
    logic [COORD_W-1:0] s_num_v [STAGES];
    logic [COORD_W-1:0] s_quo_u [STAGES];
    logic [COORD_W-1:0] s_quo_v [STAGES];
    div_side_t          s_side  [STAGES];

    // a stage loads when it is empty or its contents move on
    always_comb
    begin
        adv[STAGES] = out_ready;
        for (int j = STAGES - 1; j >= 0; j--)
        begin
            adv[j] = !valid_reg[j] || adv[j+1];
        end
    end

    assign in_ready = adv[0];

    for (genvar j = 0; j < STAGES; j++)
    begin : g_stage
        logic [SUM_W:0]   trial_u;
        logic [SUM_W:0]   trial_v;
        logic [SUM_W:0]   diff_u;
        logic [SUM_W:0]   diff_v;
        logic             ge_u;
        logic             ge_v;
        logic [SUM_W-1:0] rem_u_next;
        logic [SUM_W-1:0] rem_v_next;

        if (j == 0)
        begin : g_head
            assign s_valid[j] = in_valid;
            assign s_dmag[j]  = in_dmag;
            assign s_rem_u[j] = in_rem_u;
            assign s_rem_v[j] = in_rem_v;
            assign s_num_u[j] = in_num_u;
            assign s_num_v[j] = in_num_v;
            assign s_quo_u[j] = '0;
            assign s_quo_v[j] = '0;
            assign s_side[j]  = in_side;
        end
        else
        begin : g_body
            assign s_valid[j] = valid_reg[j-1];
            assign s_dmag[j]  = dmag_reg[j-1];
            assign s_rem_u[j] = rem_u_reg[j-1];
            assign s_rem_v[j] = rem_v_reg[j-1];
            assign s_num_u[j] = num_u_reg[j-1];
            assign s_num_v[j] = num_v_reg[j-1];
            assign s_quo_u[j] = quo_u_reg[j-1];
            assign s_quo_v[j] = quo_v_reg[j-1];
            assign s_side[j]  = side_reg[j-1];
        end

        // bring down the next dividend bit and try one subtract per lane
        assign trial_u    = {s_rem_u[j], s_num_u[j][COORD_W-1]};
        assign trial_v    = {s_rem_v[j], s_num_v[j][COORD_W-1]};
        assign diff_u     = trial_u - {1'b0, s_dmag[j]};
        assign diff_v     = trial_v - {1'b0, s_dmag[j]};
        assign ge_u       = trial_u >= {1'b0, s_dmag[j]};
        assign ge_v       = trial_v >= {1'b0, s_dmag[j]};
        assign rem_u_next = ge_u ? diff_u[SUM_W-1:0] : trial_u[SUM_W-1:0];
        assign rem_v_next = ge_v ? diff_v[SUM_W-1:0] : trial_v[SUM_W-1:0];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[j] <= 1'b0;
            end
            else if (adv[j])
            begin
                valid_reg[j] <= s_valid[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv[j])
            begin
                dmag_reg[j]  <= s_dmag[j];
                rem_u_reg[j] <= rem_u_next;
                rem_v_reg[j] <= rem_v_next;
                num_u_reg[j] <= {s_num_u[j][COORD_W-2:0], 1'b0};
                num_v_reg[j] <= {s_num_v[j][COORD_W-2:0], 1'b0};
                quo_u_reg[j] <= {s_quo_u[j][COORD_W-2:0], ge_u};
                quo_v_reg[j] <= {s_quo_v[j][COORD_W-2:0], ge_v};
                side_reg[j]  <= s_side[j];
            end
        end
    end

    assign out_valid = valid_reg[STAGES-1];
    assign quo_u     = quo_u_reg[STAGES-1];
    assign quo_v     = quo_v_reg[STAGES-1];
    assign out_side  = side_reg[STAGES-1];

endmodule

### sv/projective_point_transform.sv
`timescale 1ns / 1ps

// Maps a stream of points (u,v) through a 3x3 projective matrix in signed
// fixed point. Points enter on the src channel and leave on the dst channel,
// both valid/ready; a beat moves when valid and ready are both high.
// The matrix and the degenerate threshold sit in APB registers at 8-byte
// steps; write them only while no point is in flight.
// A src beat is accepted into the first of 37 registers that a point passes:
// one of multipliers, one of row sums, one of magnitudes, one of compares,
// one per quotient bit in the 32-stage restoring divider, and the output
// register, whose valid bit drives dst_valid.
// Throughput is one point per cycle while dst does not stall; each divider
// stage holds one subtract per coordinate, so the divider depth sets the latency.
// When dst stalls, stages fill up behind the output register while bubbles
// remain; src_ready drops only once every stage holds a point.
// Reset clears all valid bits and loads the identity matrix with a
// threshold of one unit.
// Status per point: ok, degenerate denominator (zero outputs), saturated.
module projective_point_transform #(
    parameter int FRAC_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ppt_pkg::PADDR_W-1:0]   paddr,
    input  logic [ppt_pkg::PDATA_W-1:0]   pwdata,
    output logic [ppt_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    input  logic                          src_valid,
    output logic                          src_ready,
    input  ppt_pkg::in_beat_t             src_point,
    output logic                          dst_valid,
    input  logic                          dst_ready,
    output ppt_pkg::out_beat_t            dst_point
);
    import ppt_pkg::*;

    localparam int IDX_LSB = 3;

    localparam logic [COORD_W-1:0] Q_HALF = {1'b1, {(COORD_W-1){1'b0}}};
    localparam logic [COORD_W-1:0] Q_MAX  = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic [COORD_W-1:0] Q_MIN  = {1'b1, {(COORD_W-1){1'b0}}};

    // ---------------- configuration ----------------
    logic [63:0]        row0_ab_reg;
    logic [63:0]        a02_a10_reg;
    logic [63:0]        row1_bc_reg;
    logic [63:0]        row2_ab_reg;
    logic [COEF_W-1:0]  a22_reg;
    logic [THR_W-1:0]   thresh_reg;
    logic [2:0]         reg_idx;
    logic               cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_W-1:IDX_LSB];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row0_ab_reg <= 64'(1) << (32 + FRAC_BITS);
            a02_a10_reg <= '0;
            row1_bc_reg <= 64'(1) << (32 + FRAC_BITS);
            row2_ab_reg <= '0;
            a22_reg     <= COEF_W'(1) << FRAC_BITS;
            thresh_reg  <= THR_W'(1);
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                REG_ROW0_AB: row0_ab_reg <= pwdata;
                REG_A02_A10: a02_a10_reg <= pwdata;
                REG_ROW1_BC: row1_bc_reg <= pwdata;
                REG_ROW2_AB: row2_ab_reg <= pwdata;
                REG_A22:     a22_reg     <= pwdata[COEF_W-1:0];
                REG_THRESH:  thresh_reg  <= pwdata[THR_W-1:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_ROW0_AB: prdata = row0_ab_reg;
            REG_A02_A10: prdata = a02_a10_reg;
            REG_ROW1_BC: prdata = row1_bc_reg;
            REG_ROW2_AB: prdata = row2_ab_reg;
            REG_A22:     prdata = PDATA_W'(a22_reg);
            REG_THRESH:  prdata = PDATA_W'(thresh_reg);
            default:     prdata = '0;
        endcase
    end

    // ---------------- pipeline control ----------------
    logic v1_reg, v2_reg, v3_reg, v4_reg, vo_reg;
    logic en1, en2, en3, en4, en_o;
    logic div_in_ready, div_out_valid;

    assign en_o      = !vo_reg || dst_ready;
    assign en4       = !v4_reg || div_in_ready;
    assign en3       = !v3_reg || en4;
    assign en2       = !v2_reg || en3;
    assign en1       = !v1_reg || en2;
    assign src_ready = en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= src_valid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
            if (en4)
            begin
                v4_reg <= v3_reg;
            end
            if (en_o)
            begin
                vo_reg <= div_out_valid;
            end
        end
    end

    // ---------------- stage 1: products ----------------
    logic signed [PROD_W-1:0] p_du_reg, p_dv_reg, p_uu_reg, p_uv_reg, p_vu_reg, p_vv_reg;
    logic                     last1_reg;

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            p_du_reg  <= $signed(row2_ab_reg[63:32]) * src_point.in_u;
            p_dv_reg  <= $signed(row2_ab_reg[31:0])  * src_point.in_v;
            p_uu_reg  <= $signed(row0_ab_reg[63:32]) * src_point.in_u;
            p_uv_reg  <= $signed(row0_ab_reg[31:0])  * src_point.in_v;
            p_vu_reg  <= $signed(a02_a10_reg[31:0])  * src_point.in_u;
            p_vv_reg  <= $signed(row1_bc_reg[63:32]) * src_point.in_v;
            last1_reg <= src_point.in_last;
        end
    end

    // ---------------- stage 2: row sums ----------------
    function automatic logic signed [SUM_W-1:0] ext_prod(input logic signed [PROD_W-1:0] p);
        ext_prod = {{(SUM_W-PROD_W){p[PROD_W-1]}}, p};
    endfunction

    function automatic logic signed [SUM_W-1:0] ext_coef(input logic [COEF_W-1:0] c);
        ext_coef = {{(SUM_W-COEF_W-FRAC_BITS){c[COEF_W-1]}}, c, {FRAC_BITS{1'b0}}};
    endfunction

    logic signed [SUM_W-1:0] sum_d_reg, sum_u_reg, sum_v_reg;
    logic                    last2_reg;

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            sum_d_reg <= ext_prod(p_du_reg) + ext_prod(p_dv_reg) + ext_coef(a22_reg);
            sum_u_reg <= ext_prod(p_uu_reg) + ext_prod(p_uv_reg)
                         + ext_coef(a02_a10_reg[63:32]);
            sum_v_reg <= ext_prod(p_vu_reg) + ext_prod(p_vv_reg)
                         + ext_coef(row1_bc_reg[31:0]);
            last2_reg <= last1_reg;
        end
    end

    // ---------------- stage 3: magnitudes ----------------
    function automatic logic [SUM_W-1:0] mag(input logic signed [SUM_W-1:0] s);
        mag = s[SUM_W-1] ? (SUM_W'(0) - $unsigned(s)) : $unsigned(s);
    endfunction

    logic [SUM_W-1:0] dmag3_reg, nmag_u_reg, nmag_v_reg;
    logic             dneg_reg, nneg_u_reg, nneg_v_reg, last3_reg;

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            dmag3_reg  <= mag(sum_d_reg);
            nmag_u_reg <= mag(sum_u_reg);
            nmag_v_reg <= mag(sum_v_reg);
            dneg_reg   <= sum_d_reg[SUM_W-1];
            nneg_u_reg <= sum_u_reg[SUM_W-1];
            nneg_v_reg <= sum_v_reg[SUM_W-1];
            last3_reg  <= last2_reg;
        end
    end

    // ---------------- stage 4: checks, divider setup ----------------
    // The dividend is nmag << FRAC_BITS; its part above the quotient bits
    // seeds the remainder, and if that is already >= dmag the quotient
    // cannot fit and the lane saturates.
    logic [SUM_W-1:0]   thr_scaled;
    logic [SUM_W-1:0]   rem0_u, rem0_v;
    logic [SUM_W-1:0]   dmag4_reg, rem_u_reg, rem_v_reg;
    logic [COORD_W-1:0] num_u_reg, num_v_reg;
    div_side_t          side4_reg, side4_next;

    assign thr_scaled = SUM_W'({thresh_reg, {FRAC_BITS{1'b0}}});
    assign rem0_u     = nmag_u_reg >> (COORD_W - FRAC_BITS);
    assign rem0_v     = nmag_v_reg >> (COORD_W - FRAC_BITS);

    always_comb
    begin
        side4_next.last  = last3_reg;
        side4_next.degen = (dmag3_reg == '0) || (dmag3_reg < thr_scaled);
        side4_next.sat_u = rem0_u >= dmag3_reg;
        side4_next.sat_v = rem0_v >= dmag3_reg;
        side4_next.neg_u = nneg_u_reg ^ dneg_reg;
        side4_next.neg_v = nneg_v_reg ^ dneg_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            dmag4_reg <= dmag3_reg;
            rem_u_reg <= rem0_u;
            rem_v_reg <= rem0_v;
            num_u_reg <= {nmag_u_reg[COORD_W-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
            num_v_reg <= {nmag_v_reg[COORD_W-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
            side4_reg <= side4_next;
        end
    end

    // ---------------- divider ----------------
    logic [COORD_W-1:0] quo_u, quo_v;
    div_side_t          div_side;
    div_side_t          div_side_out;

    ppt_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v4_reg),
        .in_ready  (div_in_ready),
        .in_dmag   (dmag4_reg),
        .in_rem_u  (rem_u_reg),
        .in_rem_v  (rem_v_reg),
        .in_num_u  (num_u_reg),
        .in_num_v  (num_v_reg),
        .in_side   (div_side),
        .out_valid (div_out_valid),
        .out_ready (en_o),
        .quo_u     (quo_u),
        .quo_v     (quo_v),
        .out_side  (div_side_out)
    );

    assign div_side = side4_reg;

    // ---------------- output stage: sign, clamp, status ----------------
    logic               neg_u, neg_v, sat_u, sat_v;
    logic [COORD_W-1:0] val_u, val_v;
    out_beat_t          dst_point_reg, dst_point_next;

    always_comb
    begin
        neg_u = div_side_out.neg_u && (quo_u != '0);
        neg_v = div_side_out.neg_v && (quo_v != '0);
        sat_u = div_side_out.sat_u || (neg_u ? (quo_u > Q_HALF) : quo_u[COORD_W-1]);
        sat_v = div_side_out.sat_v || (neg_v ? (quo_v > Q_HALF) : quo_v[COORD_W-1]);

        if (sat_u)
        begin
            val_u = div_side_out.neg_u ? Q_MIN : Q_MAX;
        end
        else
        begin
            val_u = neg_u ? (COORD_W'(0) - quo_u) : quo_u;
        end

        if (sat_v)
        begin
            val_v = div_side_out.neg_v ? Q_MIN : Q_MAX;
        end
        else
        begin
            val_v = neg_v ? (COORD_W'(0) - quo_v) : quo_v;
        end

        dst_point_next.out_last = div_side_out.last;
        if (div_side_out.degen)
        begin
            dst_point_next.out_u        = '0;
            dst_point_next.out_v        = '0;
            dst_point_next.point_status = ST_DEGEN;
        end
        else
        begin
            dst_point_next.out_u        = $signed(val_u);
            dst_point_next.out_v        = $signed(val_v);
            dst_point_next.point_status = (sat_u || sat_v) ? ST_SAT : ST_OK;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_o)
        begin
            dst_point_reg <= dst_point_next;
        end
    end

    assign dst_valid = vo_reg;
    assign dst_point = dst_point_reg;

`ifndef SYNTHESIS
    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid && dst_point.point_status == ST_DEGEN
            |-> dst_point.out_u == '0 && dst_point.out_v == '0)
        else $error("degenerate point with nonzero coordinates");

    a_sat_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid && dst_point.point_status == ST_SAT
            |-> dst_point.out_u == $signed(Q_MAX) || dst_point.out_u == $signed(Q_MIN)
             || dst_point.out_v == $signed(Q_MAX) || dst_point.out_v == $signed(Q_MIN))
        else $error("saturated point without a clamped coordinate");

    a_full_only_when_out: assert property (@(posedge clk) disable iff (!rst_n)
        !src_ready |-> dst_valid && !dst_ready)
        else $error("input stalled while output register can drain");
`endif

endmodule

### tb/ppt_checker.sv
`timescale 1ns / 1ps

module ppt_checker
    import ppt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    input  logic               pready,
    input  logic               src_valid,
    input  logic               src_ready,
    input  in_beat_t           src_point,
    input  logic               dst_valid,
    input  logic               dst_ready,
    input  out_beat_t          dst_point,
    output int                 pending,
    output int                 fail_count
);

    logic [63:0] coef_regs [6];
    out_beat_t   mapped_q [$];

    // (|n| << 16) / |d| with the sign of n/d, truncated toward zero and clamped to the signed 32-bit range
    function automatic logic [31:0] divide_sat(logic signed [127:0] n,
                                               logic signed [127:0] d,
                                               ref logic sat);
        logic [127:0] nmag;
        logic [127:0] dmag;
        logic [127:0] q;
        logic [127:0] lim;
        logic         neg;
        nmag = n[127] ? -n : n;
        dmag = d[127] ? -d : d;
        q    = (nmag << 16) / dmag;
        neg  = (n[127] != d[127]) && (q != 0);
        lim  = neg ? 128'h8000_0000 : 128'h7fff_ffff;
        if (q > lim) begin
            sat = 1'b1;
            q   = lim;
        end
        return neg ? (32'd0 - q[31:0]) : q[31:0];
    endfunction

    function automatic out_beat_t map_point(in_beat_t p);
        logic signed [31:0]  a00, a01, a02, a10, a11, a12, a20, a21, a22;
        logic signed [127:0] uu, vv, den, nu, nv, dmag, thr;
        logic                sat;
        out_beat_t           r;
        a00 = coef_regs[REG_ROW0_AB][63:32];
        a01 = coef_regs[REG_ROW0_AB][31:0];
        a02 = coef_regs[REG_A02_A10][63:32];
        a10 = coef_regs[REG_A02_A10][31:0];
        a11 = coef_regs[REG_ROW1_BC][63:32];
        a12 = coef_regs[REG_ROW1_BC][31:0];
        a20 = coef_regs[REG_ROW2_AB][63:32];
        a21 = coef_regs[REG_ROW2_AB][31:0];
        a22 = coef_regs[REG_A22][31:0];
        uu  = p.in_u;
        vv  = p.in_v;
        den = a20 * uu + a21 * vv + (128'(a22) <<< 16);
        dmag = den[127] ? -den : den;
        thr = {97'd0, coef_regs[REG_THRESH][30:0]} << 16;
        sat = 1'b0;
        r.out_last = p.in_last;
        if (den == 0 || dmag < thr) begin
            r.out_u = '0;
            r.out_v = '0;
            r.point_status = ST_DEGEN;
        end else begin
            nu = a00 * uu + a01 * vv + (128'(a02) <<< 16);
            nv = a10 * uu + a11 * vv + (128'(a12) <<< 16);
            r.out_u = divide_sat(nu, den, sat);
            r.out_v = divide_sat(nv, den, sat);
            r.point_status = sat ? ST_SAT : ST_OK;
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] want, logic [63:0] got);
        $display("MISMATCH %s: expected %h got %h at %0t", what, want, got, $realtime);
        fail_count++;
    endtask

    initial fail_count = 0;

    always @(posedge clk or negedge rst_n) begin
        out_beat_t want;
        if (!rst_n) begin
            coef_regs[REG_ROW0_AB] <= 64'h0001_0000_0000_0000;
            coef_regs[REG_A02_A10] <= 64'd0;
            coef_regs[REG_ROW1_BC] <= 64'h0001_0000_0000_0000;
            coef_regs[REG_ROW2_AB] <= 64'd0;
            coef_regs[REG_A22]     <= 64'h0001_0000;
            coef_regs[REG_THRESH]  <= 64'd1;
            mapped_q.delete();
            pending <= 0;
        end else begin
            if (psel && penable && pwrite && pready && paddr[5:3] < 6) begin
                if (paddr[5:3] == REG_A22)
                    coef_regs[paddr[5:3]] <= {32'd0, pwdata[31:0]};
                else if (paddr[5:3] == REG_THRESH)
                    coef_regs[paddr[5:3]] <= {33'd0, pwdata[30:0]};
                else
                    coef_regs[paddr[5:3]] <= pwdata;
            end
            if (src_valid && src_ready)
                mapped_q.push_back(map_point(src_point));
            if (dst_valid && dst_ready) begin
                if (mapped_q.size() == 0) begin
                    report_mismatch("unexpected beat", 64'd0, 64'(dst_point));
                end else begin
                    want = mapped_q.pop_front();
                    if (dst_point.out_u !== want.out_u)
                        report_mismatch("out_u", 64'(want.out_u), 64'(dst_point.out_u));
                    if (dst_point.out_v !== want.out_v)
                        report_mismatch("out_v", 64'(want.out_v), 64'(dst_point.out_v));
                    if (dst_point.point_status !== want.point_status)
                        report_mismatch("point_status", 64'(want.point_status),
                                        64'(dst_point.point_status));
                    if (dst_point.out_last !== want.out_last)
                        report_mismatch("out_last", 64'(want.out_last),
                                        64'(dst_point.out_last));
                end
            end
            pending <= mapped_q.size();
        end
    end

endmodule

### tb/tb_projective_point_transform.sv
`timescale 1ns / 1ps

module tb_projective_point_transform;
    import ppt_pkg::*;

    localparam int IDLE_LIMIT = 20000;
    localparam int DRAIN      = 60;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               src_valid = 1'b0;
    logic               src_ready;
    in_beat_t           src_point = '0;
    logic               dst_valid;
    logic               dst_ready = 1'b0;
    out_beat_t          dst_point;
    int                 pending;
    int                 fail_count;
    int                 idle_cycles = 0;
    int                 stall_left = 0;
    bit                 no_gaps = 1'b0;

    always #5 clk = ~clk;

    projective_point_transform u_top (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .src_valid(src_valid), .src_ready(src_ready), .src_point(src_point),
        .dst_valid(dst_valid), .dst_ready(dst_ready), .dst_point(dst_point)
    );

    ppt_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .src_valid(src_valid), .src_ready(src_ready), .src_point(src_point),
        .dst_valid(dst_valid), .dst_ready(dst_ready), .dst_point(dst_point),
        .pending(pending), .fail_count(fail_count)
    );

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // hold ready low for random stretches
    always @(posedge clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            dst_ready  <= 1'b0;
        end else begin
            dst_ready  <= 1'b1;
            stall_left <= gap_len();
        end
    end

    always @(posedge clk) begin
        if ((src_valid && src_ready) || (dst_valid && dst_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic apb_write(reg_idx_t idx, logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(idx) << 3;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // drop valid and wait until every accepted point has left
    task automatic drain_pipe();
        src_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    task automatic load_matrix(logic [63:0] r0, logic [63:0] r1, logic [63:0] r2,
                               logic [63:0] r3, logic [31:0] a22, logic [30:0] thr);
        drain_pipe();
        apb_write(REG_ROW0_AB, r0);
        apb_write(REG_A02_A10, r1);
        apb_write(REG_ROW1_BC, r2);
        apb_write(REG_ROW2_AB, r3);
        // junk in the unused upper bits must be dropped
        apb_write(REG_A22, {32'($urandom), a22});
        apb_write(REG_THRESH, {32'($urandom), $urandom_range(0, 1) == 1, thr});
    endtask

    task automatic send_point(logic [31:0] u, logic [31:0] v, logic last);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            src_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        src_valid <= 1'b1;
        src_point <= '{in_u: u, in_v: v, in_last: last};
        do @(posedge clk); while (!src_ready);
    endtask

    function automatic logic [31:0] pick_coef();
        case ($urandom_range(0, 5))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return 32'd0;
            3: return $urandom;
            4: return 32'($signed($urandom_range(0, 4 << 16)) - (2 << 16));
            default: return 32'($signed($urandom_range(0, 256)) - 128);
        endcase
    endfunction

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(0, 7))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2, 3: return $urandom;
            default: return 32'($signed($urandom_range(0, 200 << 16)) - (100 << 16));
        endcase
    endfunction

    function automatic logic [30:0] pick_thresh();
        case ($urandom_range(0, 5))
            0: return 31'd0;
            1, 2: return 31'd1;
            3: return 31'h7fff_ffff;
            4: return 31'($urandom);
            default: return 31'($urandom_range(0, 64));
        endcase
    endfunction

    initial begin
        int n;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // identity after reset: extremes pass straight through
        send_point(32'h0000_0000, 32'h0000_0000, 1'b0);
        send_point(32'h7fff_ffff, 32'h8000_0000, 1'b0);
        send_point(32'h8000_0000, 32'h7fff_ffff, 1'b1);
        send_point(32'h0001_0000, 32'hffff_0000, 1'b0);
        send_point(32'hffff_ffff, 32'h0000_0001, 1'b1);

        // zero denominator, also with a zero threshold
        load_matrix(64'h0001_0000_0000_0000, 0, 64'h0001_0000_0000_0000, 0, 0, 31'd0);
        send_point(32'h0001_0000, 32'h0002_0000, 1'b0);
        send_point(32'h8000_0000, 32'h7fff_ffff, 1'b1);

        // denominator just around the threshold
        load_matrix(64'h0001_0000_0000_0000, 0, 64'h0001_0000_0000_0000,
                    64'h0000_0001_0000_0000, 32'd0, 31'd2);
        send_point(32'h0001_ffff, 32'h0, 1'b0);
        send_point(32'h0002_0000, 32'h0, 1'b0);
        send_point(32'hfffe_0000, 32'h0, 1'b1);
        send_point(32'hfffe_0001, 32'h0, 1'b0);

        // tiny denominator drives both quotients into the clamp
        load_matrix(64'h7fff_ffff_8000_0000, 64'h7fff_ffff_8000_0000,
                    64'h7fff_ffff_7fff_ffff, 0, 32'd1, 31'd0);
        send_point(32'h7fff_ffff, 32'h8000_0000, 1'b0);
        send_point(32'h8000_0000, 32'h8000_0000, 1'b1);
        send_point(32'h0000_0000, 32'h0000_0000, 1'b0);
        send_point(32'h0000_0001, 32'hffff_ffff, 1'b1);

        // full-scale coefficients with negative a20, a21 and a22; the denominator is negative but for the second point
        load_matrix(64'h8000_0000_7fff_ffff, 64'h8000_0000_8000_0000,
                    64'h8000_0000_7fff_ffff, 64'h8000_0000_8000_0000,
                    32'h8000_0000, 31'h7fff_ffff);
        send_point(32'h7fff_ffff, 32'h7fff_ffff, 1'b0);
        send_point(32'h8000_0000, 32'h0001_0000, 1'b1);
        send_point(32'h0000_0000, 32'h0000_0000, 1'b0);

        for (int ph = 0; ph < 8; ph++) begin
            load_matrix({pick_coef(), pick_coef()}, {pick_coef(), pick_coef()},
                        {pick_coef(), pick_coef()}, {pick_coef(), pick_coef()},
                        pick_coef(), pick_thresh());
            no_gaps = (ph % 3 == 2);
            n = $urandom_range(60, 100);
            for (int i = 0; i < n; i++)
                send_point(pick_coord(), pick_coord(), $urandom_range(0, 1));
            src_valid <= 1'b0;
        end
        no_gaps = 1'b0;

        drain_pipe();
        if (fail_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
